// ----- sv/toce_pkg.sv -----
// ----------------------------------------------------------------------------
// toce_pkg
// shared types, codes and character helpers for the tty output expander
// ----------------------------------------------------------------------------
package toce_pkg;

    // widths
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 2;
    localparam int OP_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRLF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NL_KIND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_KIND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VT_ON    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CR_KIND  = 3'd6;

    // delay kind codes
    localparam logic [1:0] NL_COLUMN  = 2'd1;
    localparam logic [1:0] NL_FIXED   = 2'd2;
    localparam logic [1:0] TAB_DELAY  = 2'd1;
    localparam logic [1:0] TAB_EXPAND = 2'd3;
    localparam logic [1:0] CR_SHORT   = 2'd1;
    localparam logic [1:0] CR_LONG    = 2'd2;

    // delay tick counts
    localparam logic [7:0] DLY_NL_MIN = 8'd6;
    localparam logic [7:0] DLY_NL_ADD = 8'd3;
    localparam logic [3:0] DLY_TAB_BASE = 4'd9;
    localparam logic [3:0] DLY_TAB_MIN  = 4'd5;
    localparam logic [7:0] DLY_VT     = 8'd127;
    localparam logic [7:0] DLY_CR_S   = 8'd5;
    localparam logic [7:0] DLY_CR_L   = 8'd10;

    // characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] ASCII_MASK = 8'h7F;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_ESC   = 3'd1;
    localparam logic [OP_W-1:0] OP_CR    = 3'd2;
    localparam logic [OP_W-1:0] OP_CHAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SPACE = 3'd4;
    localparam logic [OP_W-1:0] OP_DELAY = 3'd5;

    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic acc_raw;
        logic acc_eot;
        logic acc_tab;
        logic acc_esc;
        logic acc_cr;
        logic dly_nz;
        logic tab_last;
    } sts_t;

    // punctuation that an upper-case-only terminal gets as backslash + stand-in
    function automatic logic needs_escape(input logic [7:0] ch);
        logic hit;
        hit = 1'b0;
        case (ch)
            8'h7B, 8'h7D, 8'h7C, CH_TILDE, 8'h60: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] ch);
        logic [7:0] r;
        r = ch;
        case (ch)
            8'h7B:    r = 8'h28;
            8'h7D:    r = 8'h29;
            8'h7C:    r = 8'h21;
            CH_TILDE: r = 8'h5E;
            8'h60:    r = 8'h27;
            default:  r = ch;
        endcase
        return r;
    endfunction

    // column after one character goes out
    function automatic logic [7:0] next_column(input logic [7:0] ch, input logic [7:0] col);
        logic [7:0] r;
        r = col;
        if (ch inside {[CH_SPACE:CH_TILDE]}) begin
            r = col + 8'd1;
        end else begin
            case (ch)
                CH_BS:
                begin
                    if (col != 8'd0) begin
                        r = col - 8'd1;
                    end
                end
                CH_LF, CH_CR: r = 8'd0;
                CH_TAB:       r = (col | 8'h07) + 8'd1;
                default:      r = col;
            endcase
        end
        return r;
    endfunction

    // delay in ticks that follows one character, zero for none
    function automatic logic [7:0] place_delay(
        input logic [7:0] ch,
        input logic [7:0] col,
        input logic [1:0] nl_kind,
        input logic [1:0] tab_kind,
        input logic       vt_on,
        input logic [1:0] cr_kind
    );
        logic [7:0] d;
        logic [7:0] nl_d;
        logic [3:0] tab_d;
        d     = 8'd0;
        nl_d  = {4'd0, col[7:4]} + DLY_NL_ADD;
        tab_d = DLY_TAB_BASE - {1'b0, col[2:0]};
        case (ch)
            CH_LF:
            begin
                if (nl_kind == NL_COLUMN) begin
                    if (col != 8'd0) begin
                        d = (nl_d < DLY_NL_MIN) ? DLY_NL_MIN : nl_d;
                    end
                end else if (nl_kind == NL_FIXED) begin
                    d = DLY_NL_MIN;
                end
            end
            CH_TAB:
            begin
                if (tab_kind == TAB_DELAY && tab_d >= DLY_TAB_MIN) begin
                    d = {4'd0, tab_d};
                end
            end
            CH_VT, CH_FF:
            begin
                if (vt_on) begin
                    d = DLY_VT;
                end
            end
            CH_CR:
            begin
                if (cr_kind == CR_SHORT) begin
                    d = DLY_CR_S;
                end else if (cr_kind == CR_LONG) begin
                    d = DLY_CR_L;
                end
            end
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/toce_dp.sv -----
// ----------------------------------------------------------------------------
// toce_dp
// datapath: config registers, character latch, column, delay and output word
// ----------------------------------------------------------------------------
module toce_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [toce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [toce_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [toce_pkg::CHAR_W-1:0]        in_char,
    input  logic                               out_stall,
    input  toce_pkg::cmd_t                     cmd,
    output toce_pkg::sts_t                     sts,
    output logic                               out_valid,
    output logic [toce_pkg::CHAR_W-1:0]        out_byte,
    output logic                               is_delay,
    output logic                               last_of_run
);
    import toce_pkg::*;

    logic       raw_reg, upper_reg, crlf_reg, vt_reg;
    logic [1:0] nl_kind_reg, tab_kind_reg, cr_kind_reg;
    logic [7:0] column_reg, column_next;
    logic [7:0] char_reg, char_next;
    logic [7:0] dly_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       is_delay_reg, last_reg;

    logic [7:0] c7;
    logic [7:0] op_char;
    logic [7:0] op_dly;
    logic [7:0] emit_byte;
    logic       is_place;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_reg      <= 1'b0;
            upper_reg    <= 1'b0;
            crlf_reg     <= 1'b0;
            nl_kind_reg  <= 2'd0;
            tab_kind_reg <= 2'd0;
            vt_reg       <= 1'b0;
            cr_kind_reg  <= 2'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RAW:      raw_reg      <= cfg_data[0];
                REG_UPPER:    upper_reg    <= cfg_data[0];
                REG_CRLF:     crlf_reg     <= cfg_data[0];
                REG_NL_KIND:  nl_kind_reg  <= cfg_data;
                REG_TAB_KIND: tab_kind_reg <= cfg_data;
                REG_VT_ON:    vt_reg       <= cfg_data[0];
                REG_CR_KIND:  cr_kind_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // incoming character classification
    assign c7 = in_char & ASCII_MASK;

    always_comb
    begin
        char_next = c7;
        if (raw_reg) begin
            char_next = in_char;
        end else if (upper_reg) begin
            if (c7 inside {[8'h61:8'h7A]}) begin
                char_next = c7 - CASE_OFS;
            end else if (needs_escape(c7)) begin
                char_next = escape_char(c7);
            end
        end
    end

    assign sts.acc_raw = raw_reg;
    assign sts.acc_eot = (c7 == CH_EOT);
    assign sts.acc_tab = (c7 == CH_TAB) && (tab_kind_reg == TAB_EXPAND);
    assign sts.acc_esc = upper_reg && needs_escape(c7);
    assign sts.acc_cr  = crlf_reg && (c7 == CH_LF);

    // character of the current operation and the delay it causes
    always_comb
    begin
        op_char  = char_reg;
        is_place = 1'b1;
        case (cmd.op)
            OP_ESC:   op_char = CH_BSL;
            OP_CR:    op_char = CH_CR;
            OP_CHAR:  op_char = char_reg;
            OP_SPACE: op_char = CH_SPACE;
            default:  is_place = 1'b0;
        endcase
    end

    always_comb
    begin
        if (raw_reg) begin
            op_dly      = 8'd0;
            column_next = column_reg;
        end else begin
            op_dly      = place_delay(op_char, column_reg, nl_kind_reg, tab_kind_reg,
                                      vt_reg, cr_kind_reg);
            column_next = next_column(op_char, column_reg);
        end
    end

    assign emit_byte    = (cmd.op == OP_DELAY) ? dly_reg : op_char;
    assign sts.dly_nz   = (op_dly != 8'd0);
    assign sts.tab_last = (column_reg[2:0] == 3'd7);
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            column_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (is_place) begin
                column_reg <= column_next;
            end
            if (cmd.op != OP_NONE) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            char_reg <= char_next;
        end
        if (is_place) begin
            dly_reg <= op_dly;
        end
        if (cmd.op != OP_NONE) begin
            out_byte_reg <= emit_byte;
            is_delay_reg <= (cmd.op == OP_DELAY);
            last_reg     <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_delay    = is_delay_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    // raw words leave the column alone
    a_raw_column: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CHAR && raw_reg) |=> $stable(column_reg))
        else $error("column moved on a raw word");

    // the final space of an expanded tab lands on a tab stop
    a_tab_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SPACE && cmd.last) |=> (column_reg[2:0] == 3'd0))
        else $error("tab expansion ended off a tab stop");

    // a word is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> (cmd.op == OP_NONE))
        else $error("output word overwritten while stalled");
`endif

endmodule

// ----- sv/toce_ctrl.sv -----
// ----------------------------------------------------------------------------
// toce_ctrl
// controller: sequences the words of one character through the datapath
// ----------------------------------------------------------------------------
module toce_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  toce_pkg::sts_t  sts,
    output toce_pkg::cmd_t  cmd
);
    import toce_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ESC      = 3'd1;
    localparam logic [2:0] S_CR       = 3'd2;
    localparam logic [2:0] S_CR_DLY   = 3'd3;
    localparam logic [2:0] S_CHAR     = 3'd4;
    localparam logic [2:0] S_CHAR_DLY = 3'd5;
    localparam logic [2:0] S_TAB      = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (sts.acc_raw) begin
                        state_next = S_CHAR;
                    end else if (sts.acc_eot) begin
                        state_next = S_IDLE;
                    end else if (sts.acc_tab) begin
                        state_next = S_TAB;
                    end else if (sts.acc_esc) begin
                        state_next = S_ESC;
                    end else if (sts.acc_cr) begin
                        state_next = S_CR;
                    end else begin
                        state_next = S_CHAR;
                    end
                end
            end
            S_ESC:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_ESC;
                    state_next = S_CHAR;
                end
            end
            S_CR:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_CR;
                    state_next = sts.dly_nz ? S_CR_DLY : S_CHAR;
                end
            end
            S_CR_DLY:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_DELAY;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_CHAR;
                    cmd.last   = !sts.dly_nz;
                    state_next = sts.dly_nz ? S_CHAR_DLY : S_IDLE;
                end
            end
            S_CHAR_DLY:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_DELAY;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TAB:
            begin
                if (sts.out_free) begin
                    cmd.op     = OP_SPACE;
                    cmd.last   = sts.tab_last;
                    state_next = sts.tab_last ? S_IDLE : S_TAB;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // words only go out when the output register can take them
    a_op_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NONE) |-> sts.out_free)
        else $error("word issued into a full output register");

    // the delay word after a character comes only from a placed character
    a_dly_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_CHAR_DLY) |-> ($past(state_reg) == S_CHAR && $past(sts.dly_nz)))
        else $error("delay word without a delaying character");

    // a dropped end-of-transmission leaves the sequencer idle
    a_eot_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !sts.acc_raw && sts.acc_eot) |=> (state_reg == S_IDLE))
        else $error("end-of-transmission was not dropped");
`endif

endmodule

// ----- sv/tty_output_character_expander.sv -----
// ----------------------------------------------------------------------------
// tty_output_character_expander
// turns characters bound for a terminal into transmit bytes and delay words
// ----------------------------------------------------------------------------
// first word: issued once the sequencer has left idle and the output is free
// throughput: one word per cycle while out_stall is low; in_stall holds the
//   input while a character's words go out (not at all for a dropped
//   end-of-transmission, longest for a tab expanded to eight spaces)
// reset: rst_n clears column, mode registers and sequencer state at once
// ----------------------------------------------------------------------------
module tty_output_character_expander (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [toce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [toce_pkg::CFG_DAT_W-1:0]      cfg_data,
    // character input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [toce_pkg::CHAR_W-1:0]         in_char,
    // transmit word output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [toce_pkg::CHAR_W-1:0]         out_byte,
    output logic                                is_delay,
    output logic                                last_of_run
);
    import toce_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: picks escape, carriage return, character, delay or tab spaces
    toce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: holds the column and the one-word output register, so the
    // next character can be taken while the last word still waits
    toce_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_char     (in_char),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .is_delay    (is_delay),
        .last_of_run (last_of_run)
    );

endmodule

// ----- test/tty_output_character_expander_tb.sv -----
// ----------------------------------------------------------------------------
// tty_output_character_expander_tb
// drives characters through the terminal output expander under many mode
// settings, predicts every transmit and delay word, and checks each one
// ----------------------------------------------------------------------------
module tty_output_character_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import toce_pkg::*;

    // index past the end of the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    // kind codes with no newline or carriage-return name in the package: both mean no delay there
    localparam logic [1:0] KIND_OFF   = 2'd0;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 4000;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 30;
    localparam int LONG_LINE_ITEMS = 40;
    localparam int PRINT_CAP       = 40;

    // one word on the transmit side
    typedef struct packed {
        logic [7:0] code;
        logic       dly;
        logic       last;
    } tx_word_t;

    // the full set of mode registers
    typedef struct packed {
        logic       raw;
        logic       upper;
        logic       crlf;
        logic [1:0] nl;
        logic [1:0] tab;
        logic       vt;
        logic [1:0] cr;
    } mode_set_t;

    // one row of the directed table: a mode change or a character
    typedef struct packed {
        logic       is_cfg;
        mode_set_t  modes;
        logic [7:0] ch;
        logic       typed_on;
        logic [1:0] n_typed;
        tx_word_t   w0;
        tx_word_t   w1;
    } stim_row_t;

    localparam mode_set_t MODES_RESET =
        '{1'b0, 1'b0, 1'b0, KIND_OFF, KIND_OFF, 1'b0, KIND_OFF};
    localparam mode_set_t MODES_RAW_ONLY =
        '{1'b1, 1'b0, 1'b0, KIND_OFF, KIND_OFF, 1'b0, KIND_OFF};
    localparam mode_set_t MODES_UPPER_CRLF =
        '{1'b0, 1'b1, 1'b1, NL_COLUMN, TAB_EXPAND, 1'b1, CR_LONG};
    localparam mode_set_t MODES_FIXED_DELAYS =
        '{1'b0, 1'b0, 1'b0, NL_FIXED, TAB_DELAY, 1'b0, CR_SHORT};
    localparam mode_set_t MODES_RAW_MAX =
        '{1'b1, 1'b1, 1'b1, KIND_SPARE, TAB_EXPAND, 1'b1, KIND_SPARE};
    localparam mode_set_t MODES_COOKED_MAX =
        '{1'b0, 1'b1, 1'b1, KIND_SPARE, TAB_EXPAND, 1'b1, KIND_SPARE};
    localparam mode_set_t MODES_COLUMN_DELAYS =
        '{1'b0, 1'b0, 1'b0, NL_COLUMN, TAB_DELAY, 1'b1, CR_SHORT};
    localparam mode_set_t MODES_LONG_LINE =
        '{1'b0, 1'b0, 1'b0, NL_COLUMN, TAB_EXPAND, 1'b0, CR_LONG};

    // ports of the block
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    in_char   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAR_W-1:0]    out_byte;
    logic                 is_delay;
    logic                 last_of_run;

    // predictor state: our own copy of the modes and the output column
    mode_set_t  modes;
    logic [7:0] column;
    tx_word_t   run_words[$];       // words caused by the character at hand
    tx_word_t   pending_words[$];   // words predicted but not yet seen

    // bookkeeping
    int mismatch_count = 0;
    int words_checked  = 0;
    int delay_words    = 0;
    int chars_sent     = 0;
    int col_wraps      = 0;
    int esc_count      = 0;
    int mode_sets      = 0;

    // stimulus shaping
    logic send_dense = 1'b0;
    int   ctrl_pct   = 10;

    tty_output_character_expander DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_delay    (is_delay),
        .last_of_run (last_of_run)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // send one 7-bit character: move the column and add any delay word after it
    function automatic void place_out(input logic [7:0] ch);
        logic [7:0] ticks;
        logic [3:0] tab_ticks;
        ticks = 8'd0;
        run_words.push_back(tx_word_t'{ch, 1'b0, 1'b0});
        if (ch >= CH_SPACE && ch <= CH_TILDE)
        begin
            if (column == 8'hFF)
                col_wraps++;
            column = column + 8'd1;
        end
        else
        begin
            case (ch)
                CH_BS:
                begin
                    // backspace stops at the left margin
                    if (column != 8'd0)
                        column = column - 8'd1;
                end
                CH_LF:
                begin
                    if (modes.nl == NL_COLUMN && column != 8'd0)
                    begin
                        // longer lines get longer delays, never below six
                        ticks = {4'd0, column[7:4]} + 8'd3;
                        if (ticks < 8'd6)
                            ticks = 8'd6;
                    end
                    else if (modes.nl == NL_FIXED)
                    begin
                        ticks = 8'd6;
                    end
                    column = 8'd0;
                end
                CH_TAB:
                begin
                    if (modes.tab == TAB_DELAY)
                    begin
                        // short hops to the next stop need no delay
                        tab_ticks = 4'd9 - {1'b0, column[2:0]};
                        if (tab_ticks >= 4'd5)
                            ticks = {4'd0, tab_ticks};
                    end
                    if (column >= 8'hF8)
                        col_wraps++;
                    column = (column | 8'h07) + 8'd1;
                end
                CH_VT, CH_FF:
                begin
                    if (modes.vt)
                        ticks = 8'd127;
                end
                CH_CR:
                begin
                    if (modes.cr == CR_SHORT)
                        ticks = 8'd5;
                    else if (modes.cr == CR_LONG)
                        ticks = 8'd10;
                    column = 8'd0;
                end
                default:
                begin
                    // other controls and rubout leave the column alone
                end
            endcase
        end
        if (ticks != 8'd0)
            run_words.push_back(tx_word_t'{ticks, 1'b1, 1'b0});
    endfunction

    // all words that one input character causes, the last one marked
    function automatic void expand_char(input logic [7:0] in_ch);
        logic [7:0] ch;
        logic [7:0] stand_in;
        tx_word_t   tail;
        int         spaces;
        run_words = {};
        ch = in_ch;
        if (modes.raw)
        begin
            run_words.push_back(tx_word_t'{ch, 1'b0, 1'b0});
        end
        else
        begin
            ch[7] = 1'b0;
            if (ch == CH_EOT)
            begin
                // end-of-transmission is swallowed
            end
            else if (ch == CH_TAB && modes.tab == TAB_EXPAND)
            begin
                // always at least one space, eight when already on a stop
                spaces = 8 - int'(column[2:0]);
                repeat (spaces) place_out(CH_SPACE);
            end
            else
            begin
                if (modes.upper)
                begin
                    if (ch >= 8'h61 && ch <= 8'h7A)
                    begin
                        ch = ch - CASE_OFS;
                    end
                    else
                    begin
                        case (ch)
                            8'h7B:    stand_in = 8'h28;     // { as \(
                            8'h7D:    stand_in = 8'h29;     // } as \)
                            8'h7C:    stand_in = 8'h21;     // | as \!
                            CH_TILDE: stand_in = 8'h5E;     // ~ as \^
                            8'h60:    stand_in = 8'h27;     // ` as \'
                            default:  stand_in = 8'h00;
                        endcase
                        if (stand_in != 8'h00)
                        begin
                            place_out(CH_BSL);
                            ch = stand_in;
                            esc_count++;
                        end
                    end
                end
                // carriage return goes out first, with its own delay
                if (ch == CH_LF && modes.crlf)
                    place_out(CH_CR);
                place_out(ch);
            end
        end
        if (run_words.size() != 0)
        begin
            tail = run_words.pop_back();
            tail.last = 1'b1;
            run_words.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t word %0d: %s is %0h, expected %0h",
                     $realtime, words_checked, what, got, want);
    endtask

    // every word taken from the block is held against the oldest prediction
    always @(posedge clk)
    begin : check_word
        tx_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_words.size() == 0)
            begin
                note_mismatch("word with nothing expected, out_byte", 32'(out_byte), 0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_byte !== want.code)
                    note_mismatch("out_byte", 32'(out_byte), 32'(want.code));
                if (is_delay !== want.dly)
                    note_mismatch("is_delay", 32'(is_delay), 32'(want.dly));
                if (last_of_run !== want.last)
                    note_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
                if (want.dly)
                    delay_words++;
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // idling on both sides
    // ------------------------------------------------------------------------

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int send_gap();
        if (send_dense || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // receiver alternates stall bursts and free runs, some free runs long
    int   stall_left = 0;
    logic stall_hold = 1'b0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_hold = !stall_hold;
            if (stall_hold)
                stall_left = idle_len();
            else if ($urandom_range(0, 99) < 15)
                stall_left = $urandom_range(40, 150);
            else
                stall_left = $urandom_range(1, 8);
        end
        stall_left--;
        out_stall <= stall_hold;
    end

    // ------------------------------------------------------------------------
    // sender and register writes
    // ------------------------------------------------------------------------

    // present one character, wait for it to be taken, then predict its words
    task automatic send_char(input stim_row_t row);
        int gap;
        gap = send_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= row.ch;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expand_char(row.ch);
        if (row.typed_on)
        begin
            // typed-in words win, the predictor only moved the column
            run_words = {};
            if (row.n_typed >= 2'd1)
                run_words.push_back(row.w0);
            if (row.n_typed >= 2'd2)
                run_words.push_back(row.w1);
        end
        foreach (run_words[k])
            pending_words.push_back(run_words[k]);
        chars_sent++;
    endtask

    // hold the input until every predicted word is out and the block has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // writes every register, then one write past the list that must do nothing
    task automatic apply_modes(input mode_set_t m);
        put_reg(REG_RAW,      {1'b0, m.raw});
        put_reg(REG_UPPER,    {1'b0, m.upper});
        put_reg(REG_CRLF,     {1'b0, m.crlf});
        put_reg(REG_NL_KIND,  m.nl);
        put_reg(REG_TAB_KIND, m.tab);
        put_reg(REG_VT_ON,    {1'b0, m.vt});
        put_reg(REG_CR_KIND,  m.cr);
        put_reg(REG_SPARE,    CFG_DAT_W'($urandom_range(0, 3)));
        cfg_we <= 1'b0;
        modes = m;
        mode_sets++;
    endtask

    function automatic mode_set_t random_modes();
        mode_set_t m;
        m.raw   = ($urandom_range(0, 5) == 0);
        m.upper = 1'($urandom_range(0, 1));
        m.crlf  = 1'($urandom_range(0, 1));
        m.nl    = 2'($urandom_range(0, 3));
        m.tab   = 2'($urandom_range(0, 3));
        m.vt    = 1'($urandom_range(0, 1));
        m.cr    = 2'($urandom_range(0, 3));
        return m;
    endfunction

    // mostly printable text so the column climbs, with controls mixed in
    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < ctrl_pct)
        begin
            case ($urandom_range(0, 6))
                0:       c = CH_BS;
                1:       c = CH_TAB;
                2:       c = CH_LF;
                3:       c = CH_VT;
                4:       c = CH_FF;
                5:       c = CH_CR;
                default: c = CH_EOT;
            endcase
            c[7] = ($urandom_range(0, 7) == 0);
        end
        else if (r < ctrl_pct + 10)
        begin
            c = 8'($urandom_range(0, 255));
        end
        else if (r < ctrl_pct + 20)
        begin
            // the escaped punctuation and lower case
            case ($urandom_range(0, 5))
                0:       c = 8'h7B;
                1:       c = 8'h7D;
                2:       c = 8'h7C;
                3:       c = CH_TILDE;
                4:       c = 8'h60;
                default: c = 8'($urandom_range(8'h61, 8'h7A));
            endcase
        end
        else
        begin
            c = 8'($urandom_range(CH_SPACE, CH_TILDE));
            c[7] = ($urandom_range(0, 9) == 0);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------------

    function automatic tx_word_t plain_word(input logic [7:0] code, input logic last);
        return tx_word_t'{code, 1'b0, last};
    endfunction

    function automatic stim_row_t cfg_row(input mode_set_t m);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.modes  = m;
        return r;
    endfunction

    function automatic stim_row_t char_row(input logic [7:0] ch);
        stim_row_t r;
        r = '0;
        r.ch = ch;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] ch, input logic [1:0] n,
                                            input tx_word_t a = '0,
                                            input tx_word_t b = '0);
        stim_row_t r;
        r = '0;
        r.ch       = ch;
        r.typed_on = 1'b1;
        r.n_typed  = n;
        r.w0       = a;
        r.w1       = b;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        stim_row_t  directed_rows[$];
        mode_set_t  m;
        logic [7:0] c;
        int         p;
        int         i;
        int         waited;

        modes  = MODES_RESET;
        column = 8'd0;

        directed_rows = '{
            // reset modes: plain text, high bit cleared, end-of-transmission dropped
            typed_row("A", 2'd1, plain_word("A", 1'b1)),
            typed_row(8'hC1, 2'd1, plain_word("A", 1'b1)),
            typed_row(CH_EOT, 2'd0),
            typed_row(8'h00, 2'd1, plain_word(8'h00, 1'b1)),
            typed_row(8'h7F, 2'd1, plain_word(8'h7F, 1'b1)),
            typed_row(CH_BS, 2'd1, plain_word(CH_BS, 1'b1)),
            typed_row(CH_TAB, 2'd1, plain_word(CH_TAB, 1'b1)),
            typed_row(CH_LF, 2'd1, plain_word(CH_LF, 1'b1)),
            // raw: bytes pass untouched, eot included
            cfg_row(MODES_RAW_ONLY),
            typed_row(8'hFF, 2'd1, plain_word(8'hFF, 1'b1)),
            typed_row(CH_EOT, 2'd1, plain_word(CH_EOT, 1'b1)),
            // upper-case terminal with cr-lf, tabs expanded, newline, vt and cr delays on
            cfg_row(MODES_UPPER_CRLF),
            typed_row("a", 2'd1, plain_word("A", 1'b1)),
            typed_row(8'h7B, 2'd2, plain_word(CH_BSL, 1'b0), plain_word(8'h28, 1'b1)),
            typed_row(CH_TILDE, 2'd2, plain_word(CH_BSL, 1'b0), plain_word(8'h5E, 1'b1)),
            char_row(8'h60),
            char_row(CH_TAB),
            char_row(CH_TAB),
            char_row(CH_LF),
            char_row(CH_VT),
            char_row(CH_FF),
            char_row(CH_CR),
            // fixed newline delay, tab delays, short cr delay
            cfg_row(MODES_FIXED_DELAYS),
            char_row("x"),
            char_row(CH_TAB),
            char_row(CH_TAB),
            char_row(CH_LF),
            char_row(CH_CR)
        };

        // reset once, then never again
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_cfg)
            begin
                wait_drained();
                apply_modes(directed_rows[k].modes);
            end
            else
            begin
                send_char(directed_rows[k]);
            end
        end

        // random phases, each under its own modes; the extremes come first
        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       m = MODES_RESET;
                1:       m = MODES_RAW_MAX;
                2:       m = MODES_COOKED_MAX;
                3:       m = MODES_COLUMN_DELAYS;
                default: m = random_modes();
            endcase
            apply_modes(m);
            send_dense = ($urandom_range(0, 2) == 0);
            // few controls in the column-delay phase so lines get long
            ctrl_pct = (p == 3) ? 3 : $urandom_range(2, 25);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // every other phase the sender holds off until the output is empty
                if (i == PHASE_ITEMS / 2 && p % 2 == 1)
                    wait_drained();
                send_char(char_row(pick_char()));
            end
        end

        // a long line of tabs and text: wraps the column, then a newline delay
        wait_drained();
        apply_modes(MODES_LONG_LINE);
        send_dense = 1'b0;
        for (i = 0; i < LONG_LINE_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                c = CH_TAB;
            else
                c = 8'($urandom_range(CH_SPACE, CH_TILDE));
            send_char(char_row(c));
        end
        send_char(char_row(CH_LF));

        // bounded wait for the tail, then a settling wait to catch stray words
        in_valid <= 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            note_mismatch("words never sent, count", pending_words.size(), 0);

        $display("sent %0d characters under %0d mode settings, checked %0d words",
                 chars_sent, mode_sets, words_checked);
        $display("  %0d delay words, %0d escapes, %0d column wraps",
                 delay_words, esc_count, col_wraps);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #15_000_000;
        $display("timeout with %0d words still expected", pending_words.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
